@@ hw/rtl/iol_pkg.sv @@
// Package for the indexed ordered list: defaults, codes and beat types.
package iol_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int ENTRY_BITS_DEF = 64;

   localparam int OP_BITS     = 2;
   localparam int POS_BITS    = 6;
   localparam int ELEM_BITS   = 64;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;

   localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_BITS-1:0] OP_READ   = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_POS = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]   operation;
      logic [POS_BITS-1:0]  position;
      logic [ELEM_BITS-1:0] element_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [ELEM_BITS-1:0]   element_out;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_type;

endpackage

@@ hw/rtl/indexed_ordered_list.sv @@
// Top level of the indexed ordered list: request decode, shift sequencer and result register.
//
//   Channel  Direction  Handshake              Beat
//   req      in         req_valid / req_ready  req_data  (operation, position, element_in)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (status, element_out, entry_count)
//
// One request is handled at a time; the list lives in a single RAM with one write and
// one read port, so an insert or remove moves the shifted entries one at a time.
// Append, an insert at the count and every refused request go straight to the finish
// step; a read first waits for the RAM data, an insert before an existing entry moves
// each entry from the last down to the position up one place and then writes the new
// one, and a remove takes its entry and moves every later entry down one place.
// Reset is synchronous and clears the count, the sticky full flag and the sequencer;
// the RAM is not cleared because only entries below the count are ever read.
// A result waiting on rsp_ready holds the sequencer in its final step; a new request
// is taken as soon as the previous result has moved into the output register.
module indexed_ordered_list_core
   import iol_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CNTW = $clog2(CAPACITY + 1);
   // Common width for comparing a request position against the count.
   localparam int CMPW = (CNTW > POS_BITS) ? CNTW : POS_BITS;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_RD_WAIT  = 3'd1;
   localparam logic [2:0] ST_SHIFT_UP = 3'd2;
   localparam logic [2:0] ST_INS_PUT  = 3'd3;
   localparam logic [2:0] ST_REM_TAKE = 3'd4;
   localparam logic [2:0] ST_SHIFT_DN = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   // Sequencer and list state.
   logic [2:0]             state_ff, state_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic                   ovf_ff, ovf_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [ENTRY_BITS-1:0]  data_ff, data_in;
   logic [ENTRY_BITS-1:0]  elem_ff, elem_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   // RAM port signals.
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;

   // Request decode helpers.
   logic            req_accept;
   logic [CMPW-1:0] req_pos_cmp;
   logic [CMPW-1:0] cnt_cmp;
   logic            list_full;
   logic [CNTW-1:0] ptr_up_cnt;
   logic            more_to_move;

   iol_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign req_pos_cmp = CMPW'(req_data.position);
   assign cnt_cmp     = CMPW'(cnt_ff);
   assign list_full   = (cnt_ff == CNTW'(CAPACITY));
   // The entry after the pointer still lies inside the list.
   assign ptr_up_cnt   = CNTW'(ptr_ff) + CNTW'(1);
   assign more_to_move = (ptr_up_cnt < cnt_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      data_in      = data_ff;
      elem_in      = elem_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = data_ff;
      rd_en   = 1'b0;
      rd_addr = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pos_in    = AW'(req_data.position);
               data_in   = req_data.element_in[ENTRY_BITS-1:0];
               elem_in   = '0;
               status_in = STATUS_OK;
               state_in  = ST_FINISH;
               unique case (req_data.operation)
                  OP_APPEND: begin
                     if (ovf_ff) begin
                        status_in = STATUS_FULL;
                     end else if (list_full) begin
                        ovf_in    = 1'b1;
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(cnt_ff);
                        wr_data = req_data.element_in[ENTRY_BITS-1:0];
                        cnt_in  = cnt_ff + CNTW'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (req_pos_cmp > cnt_cmp) begin
                        status_in = STATUS_BAD_POS;
                     end else if (ovf_ff) begin
                        status_in = STATUS_FULL;
                     end else if (list_full) begin
                        ovf_in    = 1'b1;
                        status_in = STATUS_FULL;
                     end else if (req_pos_cmp == cnt_cmp) begin
                        // Insert at the end behaves as an append.
                        wr_en   = 1'b1;
                        wr_addr = AW'(req_data.position);
                        wr_data = req_data.element_in[ENTRY_BITS-1:0];
                        cnt_in  = cnt_ff + CNTW'(1);
                     end else begin
                        // Start moving entries up from the last one.
                        rd_en    = 1'b1;
                        rd_addr  = AW'(cnt_ff - CNTW'(1));
                        ptr_in   = AW'(cnt_ff - CNTW'(1));
                        state_in = ST_SHIFT_UP;
                     end
                  end
                  OP_REMOVE: begin
                     if (req_pos_cmp >= cnt_cmp) begin
                        status_in = STATUS_BAD_POS;
                     end else if (ovf_ff) begin
                        status_in = STATUS_FULL;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_data.position);
                        ptr_in   = AW'(req_data.position);
                        state_in = ST_REM_TAKE;
                     end
                  end
                  OP_READ: begin
                     if (req_pos_cmp >= cnt_cmp) begin
                        status_in = STATUS_BAD_POS;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_data.position);
                        state_in = ST_RD_WAIT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_RD_WAIT: begin
            elem_in  = rd_data;
            state_in = ST_FINISH;
         end

         ST_SHIFT_UP: begin
            // The entry read last cycle moves one place up; the next lower one is read.
            wr_en   = 1'b1;
            wr_addr = ptr_ff + AW'(1);
            wr_data = rd_data;
            if (ptr_ff == pos_ff) begin
               state_in = ST_INS_PUT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff - AW'(1);
               ptr_in  = ptr_ff - AW'(1);
            end
         end

         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = data_ff;
            cnt_in   = cnt_ff + CNTW'(1);
            state_in = ST_FINISH;
         end

         ST_REM_TAKE: begin
            elem_in = rd_data;
            if (more_to_move) begin
               rd_en    = 1'b1;
               rd_addr  = ptr_ff + AW'(1);
               ptr_in   = ptr_ff + AW'(1);
               state_in = ST_SHIFT_DN;
            end else begin
               cnt_in   = cnt_ff - CNTW'(1);
               state_in = ST_FINISH;
            end
         end

         ST_SHIFT_DN: begin
            // The entry read last cycle moves one place down; the next higher one is read.
            wr_en   = 1'b1;
            wr_addr = ptr_ff - AW'(1);
            wr_data = rd_data;
            if (more_to_move) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + AW'(1);
               ptr_in  = ptr_ff + AW'(1);
            end else begin
               cnt_in   = cnt_ff - CNTW'(1);
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // The result waits here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.element_out = ELEM_BITS'(elem_ff);
               rsp_in.entry_count = COUNT_BITS'(cnt_ff);
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      data_ff   <= data_in;
      elem_ff   <= elem_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/iol_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module iol_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
